### rtl/sssm_pkg.sv
// Shared constants and types for the staircase search core.
// No dependencies; imported by staircase_search_sorted_matrix_core.
`timescale 1ns / 1ps

package sssm_pkg;

   localparam int MAX_ROWS    = 16;
   localparam int MAX_COLS    = 16;
   localparam int VALUE_WIDTH = 32;

   localparam int ROW_W   = $clog2(MAX_ROWS);
   localparam int COL_W   = $clog2(MAX_COLS);
   localparam int ADDR_W  = ROW_W + COL_W;
   localparam int DEPTH   = MAX_ROWS * MAX_COLS;
   localparam int SIZE_W  = 5;
   localparam int CSR_A_W = 1;
   localparam int REQ_DATA_W = ((ROW_W + COL_W + VALUE_WIDTH + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((ROW_W + COL_W + 7) / 8) * 8;

   localparam logic [SIZE_W-1:0] ROWS_LIMIT = SIZE_W'(MAX_ROWS);
   localparam logic [SIZE_W-1:0] COLS_LIMIT = SIZE_W'(MAX_COLS);

   // configuration register indexes
   localparam logic [CSR_A_W-1:0] CSR_ROWS_IN_USE = 1'b0;
   localparam logic [CSR_A_W-1:0] CSR_COLS_IN_USE = 1'b1;

   // request kinds
   localparam logic REQ_WRITE  = 1'b0;
   localparam logic REQ_SEARCH = 1'b1;

   typedef logic signed [VALUE_WIDTH-1:0] value_type;

   typedef enum logic [4:0] {
      S_IDLE      = 5'b00001,
      S_CHK_FIRST = 5'b00010,
      S_CHK_LAST  = 5'b00100,
      S_WALK      = 5'b01000,
      S_DONE      = 5'b10000
   } state_type;

endpackage

### rtl/staircase_search_sorted_matrix_core.sv
// Staircase search over a row- and column-sorted matrix held in one RAM.
// Depends on sssm_pkg (sizes, request kinds, register indexes, state codes).
`timescale 1ns / 1ps

// Usage
//   req channel: one word per request. req_tuser = kind (0 write, 1 search).
//     A write stores data_value at (row_index, col_index) and returns nothing;
//     it leaves the core idle, so the core stays ready for the next request.
//   A search returns exactly one rsp word: rsp_tuser = found, with the
//     row and column of the hit in rsp_tdata (zeros when not found).
//   A search is accepted, then checked early against the top-left and
//     bottom-right elements, then walks one cell per cycle (at most
//     rows + cols - 1 cells, i.e. 31 at 16x16), then loads the output
//     register; the walk is bound by the single read port of the matrix RAM.
//   csr port: writes rows_in_use (index 0) / cols_in_use (index 1); the user writes
//     only while the core is idle, unenforced. Values above 16 act as 16, zero as empty.
//   Reset: synchronous, sizes go to 16x16, control idles; the matrix RAM is
//     not cleared, cells must be written before a search reads them.
//     req_tready stays low while reset is high.
//   Stall: a result waits in the output register while new requests are
//     taken; a second result waits in the done state until the slot frees.
module staircase_search_sorted_matrix_core (
   input  logic                               clock,
   input  logic                               reset,
   // request: [3:0] row_index, [7:4] col_index, [39:8] data_value
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [sssm_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                               req_tuser,   // [0] req_type
   // response: [3:0] found_row, [7:4] found_col
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [sssm_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                               rsp_tuser,   // [0] found
   // configuration
   input  logic                               csr_we,
   input  logic [sssm_pkg::CSR_A_W-1:0]       csr_addr,
   input  logic [sssm_pkg::SIZE_W-1:0]        csr_wdata
);
   import sssm_pkg::*;

   // request fields
   logic [ROW_W-1:0] req_row;
   logic [COL_W-1:0] req_col;
   value_type        req_value;
   logic             req_accept;

   assign req_row    = req_tdata[ROW_W-1:0];
   assign req_col    = req_tdata[ROW_W+COL_W-1:ROW_W];
   assign req_value  = req_tdata[ROW_W+COL_W+VALUE_WIDTH-1:ROW_W+COL_W];
   assign req_accept = req_tvalid && req_tready;

   // config registers
   logic [SIZE_W-1:0] rows_in_use_ff, cols_in_use_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_in_use_ff <= ROWS_LIMIT;
         cols_in_use_ff <= COLS_LIMIT;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_ROWS_IN_USE: rows_in_use_ff <= csr_wdata;
            CSR_COLS_IN_USE: cols_in_use_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // clamped sizes, sampled when a search starts
   logic [SIZE_W-1:0] rows_clamp, cols_clamp;
   assign rows_clamp = (rows_in_use_ff > ROWS_LIMIT) ? ROWS_LIMIT : rows_in_use_ff;
   assign cols_clamp = (cols_in_use_ff > COLS_LIMIT) ? COLS_LIMIT : cols_in_use_ff;

   // matrix RAM: one write port, one registered read port
   value_type         mem [DEPTH];
   value_type         rd_data_ff;
   logic [ADDR_W-1:0] rd_addr;
   logic              mem_we;

   assign mem_we = req_accept && (req_tuser == REQ_WRITE);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[{req_row, req_col}] <= req_value;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // search control
   state_type         state_ff, state_in;
   value_type         key_ff, key_in;
   logic [SIZE_W-1:0] rows_act_ff, rows_act_in;
   logic [SIZE_W-1:0] cols_act_ff, cols_act_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic              res_found_ff, res_found_in;
   logic [ROW_W-1:0]  res_row_ff, res_row_in;
   logic [COL_W-1:0]  res_col_ff, res_col_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_found_ff, rsp_found_in;
   logic [ROW_W-1:0]  rsp_row_ff, rsp_row_in;
   logic [COL_W-1:0]  rsp_col_ff, rsp_col_in;
   logic              slot_free;

   logic [SIZE_W-1:0] rows_m1, cols_m1;
   assign rows_m1 = rows_act_ff - SIZE_W'(1);
   assign cols_m1 = cols_act_ff - SIZE_W'(1);

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && !reset;

   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      rows_act_in  = rows_act_ff;
      cols_act_in  = cols_act_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      res_found_in = res_found_ff;
      res_row_in   = res_row_ff;
      res_col_in   = res_col_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_found_in = rsp_found_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rd_addr      = '0;

      unique case (state_ff)
         S_IDLE: begin
            // read of the top-left cell goes out in the accept cycle
            rd_addr = '0;
            if (req_accept && (req_tuser == REQ_SEARCH)) begin
               key_in       = req_value;
               rows_act_in  = rows_clamp;
               cols_act_in  = cols_clamp;
               res_found_in = 1'b0;
               res_row_in   = '0;
               res_col_in   = '0;
               if (rows_clamp == '0 || cols_clamp == '0) begin
                  state_in = S_DONE;   // empty matrix
               end else begin
                  state_in = S_CHK_FIRST;
               end
            end
         end
         S_CHK_FIRST: begin
            rd_addr = {rows_m1[ROW_W-1:0], cols_m1[COL_W-1:0]};
            if (key_ff < rd_data_ff) begin
               state_in = S_DONE;
            end else begin
               state_in = S_CHK_LAST;
            end
         end
         S_CHK_LAST: begin
            // start at the top-right corner
            row_in  = '0;
            col_in  = cols_m1[COL_W-1:0];
            rd_addr = {row_in, col_in};
            if (rd_data_ff < key_ff) begin
               state_in = S_DONE;
            end else begin
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            if (rd_data_ff == key_ff) begin
               res_found_in = 1'b1;
               res_row_in   = row_ff;
               res_col_in   = col_ff;
               state_in     = S_DONE;
            end else if (rd_data_ff > key_ff) begin
               if (col_ff == '0) begin
                  state_in = S_DONE;
               end else begin
                  col_in = col_ff - COL_W'(1);
               end
            end else begin
               if ({1'b0, row_ff} == rows_m1) begin
                  state_in = S_DONE;
               end else begin
                  row_in = row_ff + ROW_W'(1);
               end
            end
            rd_addr = {row_in, col_in};
         end
         S_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = res_found_ff;
               rsp_row_in   = res_row_ff;
               rsp_col_in   = res_col_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      rows_act_ff  <= rows_act_in;
      cols_act_ff  <= cols_act_in;
      row_ff       <= row_in;
      col_ff       <= col_in;
      res_found_ff <= res_found_in;
      res_row_ff   <= res_row_in;
      res_col_ff   <= res_col_in;
      rsp_found_ff <= rsp_found_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_col_ff, rsp_row_ff});

   // checks
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_found_ff |-> rsp_row_ff == '0 && rsp_col_ff == '0)
      else $error("miss reported with nonzero position");

   a_search_starts: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_tuser == REQ_SEARCH |=> state_ff != S_IDLE)
      else $error("search accepted but control stayed idle");

   a_walk_bounds: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WALK |-> {1'b0, row_ff} < rows_act_ff && {1'b0, col_ff} < cols_act_ff)
      else $error("walk position left the area in use");

   a_done_emits: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE && slot_free |=> rsp_valid_ff && state_ff == S_IDLE)
      else $error("result not loaded when output slot was free");

endmodule
